### rtl/core/pdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_pkg
// shared types and constants for the difficulty retarget core
// ----------------------------------------------------------------------------
package pdr_pkg;

    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int SUM_W      = 48;
    localparam int CHANGE_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // restoring divide produces one quotient bit per step
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [SUM_W-1:0]   SUM_MAX          = {SUM_W{1'b1}};
    localparam logic [COUNT_W-1:0] DEFAULT_INTERVAL = COUNT_W'(10);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL  = CFG_IDX_W'(4);

    // reset values
    localparam logic [LEVEL_W-1:0] RST_INIT_LEVEL = LEVEL_W'(20);
    localparam logic [TIME_W-1:0]  RST_TARGET     = TIME_W'(5000);
    localparam logic [COUNT_W-1:0] RST_INTERVAL   = COUNT_W'(10);
    localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL  = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] RST_MAX_LEVEL  = LEVEL_W'(255);

    // change codes
    localparam logic [CHANGE_W-1:0] CHG_NONE  = CHANGE_W'(0);
    localparam logic [CHANGE_W-1:0] CHG_RAISE = CHANGE_W'(1);
    localparam logic [CHANGE_W-1:0] CHG_LOWER = CHANGE_W'(2);

    typedef struct packed {
        logic [LEVEL_W-1:0] init_level;
        logic [TIME_W-1:0]  target;
        logic [COUNT_W-1:0] interval;   // zero already replaced by the default
        logic [LEVEL_W-1:0] min_level;
        logic [LEVEL_W-1:0] max_level;
    } cfg_t;

endpackage

### rtl/core/pdr_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_regs
// configuration register file with write decode
// ----------------------------------------------------------------------------
module pdr_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             wr_en,
    input  logic [pdr_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [pdr_pkg::CFG_DATA_W-1:0]   wr_data,
    output pdr_pkg::cfg_t                    cfg,
    output logic                             init_load
);

    logic [pdr_pkg::LEVEL_W-1:0] init_level_reg;
    logic [pdr_pkg::TIME_W-1:0]  target_reg;
    logic [pdr_pkg::COUNT_W-1:0] interval_reg;
    logic [pdr_pkg::LEVEL_W-1:0] min_level_reg;
    logic [pdr_pkg::LEVEL_W-1:0] max_level_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_level_reg <= pdr_pkg::RST_INIT_LEVEL;
            target_reg     <= pdr_pkg::RST_TARGET;
            interval_reg   <= pdr_pkg::RST_INTERVAL;
            min_level_reg  <= pdr_pkg::RST_MIN_LEVEL;
            max_level_reg  <= pdr_pkg::RST_MAX_LEVEL;
        end else if (wr_en) begin
            unique case (wr_index)
                pdr_pkg::REG_INIT_LEVEL: init_level_reg <= wr_data[pdr_pkg::LEVEL_W-1:0];
                pdr_pkg::REG_TARGET:     target_reg     <= wr_data[pdr_pkg::TIME_W-1:0];
                pdr_pkg::REG_INTERVAL:   interval_reg   <= wr_data[pdr_pkg::COUNT_W-1:0];
                pdr_pkg::REG_MIN_LEVEL:  min_level_reg  <= wr_data[pdr_pkg::LEVEL_W-1:0];
                pdr_pkg::REG_MAX_LEVEL:  max_level_reg  <= wr_data[pdr_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // the level load uses the written value directly, same cycle as the write
    assign init_load = wr_en && (wr_index == pdr_pkg::REG_INIT_LEVEL);

    always_comb begin
        cfg.init_level = init_load ? wr_data[pdr_pkg::LEVEL_W-1:0] : init_level_reg;
        cfg.target     = target_reg;
        cfg.interval   = (interval_reg == '0) ? pdr_pkg::DEFAULT_INTERVAL : interval_reg;
        cfg.min_level  = min_level_reg;
        cfg.max_level  = max_level_reg;
    end

endmodule

### rtl/core/pdr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_divider
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pdr_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pdr_pkg::SUM_W-1:0]      dividend,
    input  logic [pdr_pkg::COUNT_W-1:0]    divisor,
    output logic                           done,
    output logic [pdr_pkg::SUM_W-1:0]      quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [pdr_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [pdr_pkg::COUNT_W-1:0]     rem_reg;
    logic [pdr_pkg::COUNT_W-1:0]     rem_next;
    logic [pdr_pkg::SUM_W-1:0]       quo_reg;
    logic [pdr_pkg::SUM_W-1:0]       quo_next;
    logic [pdr_pkg::COUNT_W-1:0]     div_reg;
    logic [pdr_pkg::COUNT_W:0]       shifted;
    logic [pdr_pkg::COUNT_W:0]       diff;

    // shared subtract and compare
    always_comb begin
        shifted = {rem_reg, quo_reg[pdr_pkg::SUM_W-1]};
        diff    = shifted - {1'b0, div_reg};
        if (shifted >= {1'b0, div_reg}) begin
            rem_next = diff[pdr_pkg::COUNT_W-1:0];
            quo_next = {quo_reg[pdr_pkg::SUM_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[pdr_pkg::COUNT_W-1:0];
            quo_next = {quo_reg[pdr_pkg::SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == pdr_pkg::DIV_CNT_W'(pdr_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/core/pow_difficulty_retarget_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pow_difficulty_retarget_core
// difficulty retarget from reported solve times over an averaging window
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item per measured solve time (ms), valid/ready
//   m_* channel: one item per report with the current difficulty, a flag
//     for a closed window and the change code (none, raised, lowered)
//   cfg_* channel: register writes, always ready; a write to the initial
//     level reloads the difficulty and clears the window
// sequence
//   a report that does not close the window goes from the accumulate step
//   to emit; a closing report first runs the 48-step serial divide of the
//   window sum by the report count, then the decide step, then emit
// flow
//   one item at a time: s_ready is high only while the sequencer is idle,
//   so a new item is taken only once the last has reached the output slot
// reset
//   synchronous active-low; registers take their reset values, the level
//   loads the initial level and the window is empty
// stall
//   the result sits in an output register; the next item is taken while it
//   waits, but that item's result is held back until the slot is free
// ----------------------------------------------------------------------------
module pow_difficulty_retarget_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // report input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pdr_pkg::TIME_W-1:0]        s_solve_time,
    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pdr_pkg::LEVEL_W-1:0]       m_difficulty,
    output logic                              m_window_closed,
    output logic [pdr_pkg::CHANGE_W-1:0]      m_change,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pdr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pdr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ACCUM  = 5'b00010,
        ST_DIV    = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    pdr_pkg::cfg_t cfg;
    logic          init_load;

    // window and level state
    logic [pdr_pkg::COUNT_W-1:0]  count_reg, count_next;
    logic [pdr_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic [pdr_pkg::LEVEL_W-1:0]  level_reg, level_next;
    logic [pdr_pkg::TIME_W-1:0]   time_reg;

    // pending result for the output slot
    logic                         closed_reg, closed_next;
    logic [pdr_pkg::CHANGE_W-1:0] change_reg, change_next;

    // output slot
    logic                         m_valid_reg;
    logic [pdr_pkg::LEVEL_W-1:0]  m_level_reg;
    logic                         m_closed_reg;
    logic [pdr_pkg::CHANGE_W-1:0] m_change_reg;

    // accumulate path
    logic [pdr_pkg::COUNT_W-1:0]  count_inc;
    logic [pdr_pkg::SUM_W:0]      sum_add;
    logic [pdr_pkg::SUM_W-1:0]    sum_sat;
    logic                         close_now;

    // divider and thresholds
    logic                         div_start;
    logic                         div_done;
    logic [pdr_pkg::SUM_W-1:0]    avg;
    logic [pdr_pkg::SUM_W-1:0]    thr_lo;
    logic [pdr_pkg::SUM_W-1:0]    thr_hi;

    logic                         in_fire;
    logic                         emit_fire;

    pdr_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (cfg_valid),
        .wr_index  (cfg_index),
        .wr_data   (cfg_data),
        .cfg       (cfg),
        .init_load (init_load)
    );

    pdr_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_sat),
        .divisor  (count_inc),
        .done     (div_done),
        .quotient (avg)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_fire   = s_valid && s_ready;
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // count wraps at 16 bits, sum saturates at the top of 48 bits
    assign count_inc = count_reg + 1'b1;
    assign sum_add   = {1'b0, sum_reg} + {{(pdr_pkg::SUM_W + 1 - pdr_pkg::TIME_W){1'b0}}, time_reg};
    assign sum_sat   = sum_add[pdr_pkg::SUM_W] ? pdr_pkg::SUM_MAX : sum_add[pdr_pkg::SUM_W-1:0];
    assign close_now = (count_inc != '0) && (count_inc >= cfg.interval);

    // floor(target/2) and target*2, both exact
    assign thr_lo = {{(pdr_pkg::SUM_W - pdr_pkg::TIME_W + 1){1'b0}},
                     cfg.target[pdr_pkg::TIME_W-1:1]};
    assign thr_hi = {{(pdr_pkg::SUM_W - pdr_pkg::TIME_W - 1){1'b0}}, cfg.target, 1'b0};

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        level_next  = level_reg;
        closed_next = closed_reg;
        change_next = change_reg;
        div_start   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                count_next = count_inc;
                sum_next   = sum_sat;
                if (close_now) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    closed_next = 1'b0;
                    change_next = pdr_pkg::CHG_NONE;
                    state_next  = ST_EMIT;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                change_next = pdr_pkg::CHG_NONE;
                if (avg < thr_lo) begin
                    if (level_reg < cfg.max_level) begin
                        level_next  = level_reg + 1'b1;
                        change_next = pdr_pkg::CHG_RAISE;
                    end
                end else if (avg > thr_hi) begin
                    if (level_reg > cfg.min_level) begin
                        level_next  = level_reg - 1'b1;
                        change_next = pdr_pkg::CHG_LOWER;
                    end
                end
                count_next  = '0;
                sum_next    = '0;
                closed_next = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // initial level write reloads the level and empties the window
        if (init_load) begin
            level_next = cfg.init_level;
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            level_reg   <= pdr_pkg::RST_INIT_LEVEL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            level_reg <= level_next;
            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        closed_reg <= closed_next;
        change_reg <= change_next;
        if (in_fire) begin
            time_reg <= s_solve_time;
        end
        if (emit_fire) begin
            m_level_reg  <= level_reg;
            m_closed_reg <= closed_reg;
            m_change_reg <= change_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_difficulty    = m_level_reg;
    assign m_window_closed = m_closed_reg;
    assign m_change        = m_change_reg;

endmodule

### rtl/core/pdr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdr_checker
// port-level checks for the difficulty retarget core
// ----------------------------------------------------------------------------
module pdr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [pdr_pkg::LEVEL_W-1:0]       m_difficulty,
    input logic                              m_window_closed,
    input logic [pdr_pkg::CHANGE_W-1:0]      m_change
);

    // a held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_difficulty)
            && $stable(m_window_closed) && $stable(m_change))
        else $error("result changed while stalled");

    // only a closing report may carry a change
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_window_closed |-> m_change == pdr_pkg::CHG_NONE)
        else $error("change reported without window close");

    // change code is one of the defined codes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_change == pdr_pkg::CHG_NONE || m_change == pdr_pkg::CHG_RAISE
            || m_change == pdr_pkg::CHG_LOWER)
        else $error("undefined change code");

    // one report at a time: ready drops right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while busy");

endmodule

bind pow_difficulty_retarget_core pdr_checker u_pdr_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_difficulty    (m_difficulty),
    .m_window_closed (m_window_closed),
    .m_change        (m_change)
);
